[sv/adsc_pkg.sv]
// ----------------------------------------------------------------------------
// adsc_pkg: shared types for the advertising-data structure classifier
// Item layouts and class codes used by the parser and the top level.
// ----------------------------------------------------------------------------
package adsc_pkg;

  // One payload byte per item.
  typedef struct packed {
    logic [7:0] ad_byte;
    logic       last_byte;
  } adsc_in_t;

  // One classification per payload.
  typedef struct packed {
    logic [1:0] ad_class;
    logic [2:0] mfg_class;
  } adsc_out_t;

  localparam logic [1:0] AD_SVC_DATA   = 2'd0;
  localparam logic [1:0] AD_UUID16     = 2'd1;
  localparam logic [1:0] AD_FLAGS_ONLY = 2'd2;
  localparam logic [1:0] AD_OTHER      = 2'd3;

  localparam logic [2:0] MFG_NAME       = 3'd0;
  localparam logic [2:0] MFG_APPEARANCE = 3'd1;
  localparam logic [2:0] MFG_TX_POWER   = 3'd2;
  localparam logic [2:0] MFG_FLAGS      = 3'd3;
  localparam logic [2:0] MFG_ONLY       = 3'd4;

endpackage

[sv/adsc_parser.sv]
// ----------------------------------------------------------------------------
// adsc_parser: LTV element walker and classifier
// Holds the parse state, updates it once per stepped byte up to the 255th of a
// payload, and forms the classes from the updated type marks on the final byte.
// ----------------------------------------------------------------------------
module adsc_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  adsc_pkg::adsc_in_t item,
  output adsc_pkg::adsc_out_t result
);
  import adsc_pkg::*;

  typedef enum logic [1:0] {
    PH_LEN   = 2'd0,
    PH_TYPE  = 2'd1,
    PH_VALUE = 2'd2,
    PH_STOP  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    TC_OTHER   = 3'd0,
    TC_FLAGS   = 3'd1,
    TC_UUID16  = 3'd2,
    TC_SVCDATA = 3'd3,
    TC_NAME    = 3'd4,
    TC_APPEAR  = 3'd5,
    TC_TXPOWER = 3'd6
  } tcode_t;

  localparam logic [7:0] MAX_PAYLOAD = 8'd255;

  phase_t     phase, phase_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] bytes_seen, bytes_seen_next;
  tcode_t     pending, pending_next;
  logic [6:0] marks, marks_next;
  tcode_t     byte_code;

  always_comb begin
    case (item.ad_byte)
      8'h01:        byte_code = TC_FLAGS;
      8'h02, 8'h03: byte_code = TC_UUID16;
      8'h16:        byte_code = TC_SVCDATA;
      8'h08, 8'h09: byte_code = TC_NAME;
      8'h19:        byte_code = TC_APPEAR;
      8'h0A:        byte_code = TC_TXPOWER;
      default:      byte_code = TC_OTHER;
    endcase
  end

  // Next parse state for this byte (before the end-of-payload reset).
  always_comb begin
    phase_next      = phase;
    bytes_left_next = bytes_left;
    bytes_seen_next = bytes_seen;
    pending_next    = pending;
    marks_next      = marks;
    if (bytes_seen < MAX_PAYLOAD) begin
      bytes_seen_next = bytes_seen + 8'd1;
      case (phase)
        PH_LEN: begin
          if (item.ad_byte == 8'd0) begin
            phase_next = PH_STOP;
          end else begin
            bytes_left_next = item.ad_byte;
            phase_next      = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (bytes_left <= 8'd1) begin
            marks_next[byte_code] = 1'b1;
            bytes_left_next       = 8'd0;
            phase_next            = PH_LEN;
          end else begin
            bytes_left_next = bytes_left - 8'd1;
            pending_next    = byte_code;
            phase_next      = PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (bytes_left <= 8'd1) begin
            bytes_left_next     = 8'd0;
            marks_next[pending] = 1'b1;
            phase_next          = PH_LEN;
          end else begin
            bytes_left_next = bytes_left - 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Classes from the marks including this byte's element.
  always_comb begin
    if (marks_next[TC_SVCDATA]) begin
      result.ad_class = AD_SVC_DATA;
    end else if (marks_next[TC_UUID16]) begin
      result.ad_class = AD_UUID16;
    end else if (marks_next[TC_FLAGS] && !(marks_next[TC_OTHER] || marks_next[TC_NAME] ||
                 marks_next[TC_APPEAR] || marks_next[TC_TXPOWER])) begin
      result.ad_class = AD_FLAGS_ONLY;
    end else begin
      result.ad_class = AD_OTHER;
    end

    if (marks_next[TC_NAME]) begin
      result.mfg_class = MFG_NAME;
    end else if (marks_next[TC_APPEAR]) begin
      result.mfg_class = MFG_APPEARANCE;
    end else if (marks_next[TC_TXPOWER]) begin
      result.mfg_class = MFG_TX_POWER;
    end else if (marks_next[TC_FLAGS]) begin
      result.mfg_class = MFG_FLAGS;
    end else begin
      result.mfg_class = MFG_ONLY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      phase      <= PH_LEN;
      bytes_left <= 8'd0;
      bytes_seen <= 8'd0;
      pending    <= TC_OTHER;
      marks      <= 7'd0;
    end else if (step) begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
      bytes_seen <= bytes_seen_next;
      pending    <= pending_next;
      marks      <= marks_next;
    end
  end

endmodule

[sv/ble_ad_structure_classifier_unit.sv]
// ----------------------------------------------------------------------------
// ble_ad_structure_classifier_unit: BLE advertising-data classifier
// Input byte register, parser, and result register with handshakes.
// ----------------------------------------------------------------------------
// Takes one advertising-data payload byte per item on ad_*, and on the item
// flagged last_byte delivers one result item on res_* carrying the structure
// class and the manufacturer-advert class of that payload. Items flow at one
// per cycle unless a last byte waits: a byte that need not wait is parsed in
// the cycle after it is taken, so res_valid rises at the edge after the last
// byte is accepted when the result slot is free; the result can then be taken.
// Non-last bytes never wait on the result side; a last byte waits in the input
// register only while an earlier result is still held and not taken. After
// each result the parser is back in its reset state for the next payload.
// Bytes past the 255th of a payload are ignored except for their last flag.
// ----------------------------------------------------------------------------
module ble_ad_structure_classifier_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                ad_valid,
  output logic                ad_ready,
  input  adsc_pkg::adsc_in_t  ad_data,
  output logic                res_valid,
  input  logic                res_ready,
  output adsc_pkg::adsc_out_t res_data
);
  import adsc_pkg::*;

  // input register
  logic      hold_valid;
  adsc_in_t  hold_item;
  // parser step and its classes
  logic      advance;
  adsc_out_t classes;

  // A last byte needs a free result slot; any other byte moves on at once.
  assign advance  = hold_valid && (!hold_item.last_byte || !res_valid || res_ready);
  assign ad_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (ad_ready) begin
      hold_valid <= ad_valid;
    end
    if (ad_ready && ad_valid) begin
      hold_item <= ad_data;
    end
  end

  adsc_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (hold_item),
    .result (classes)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && hold_item.last_byte) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (advance && hold_item.last_byte) begin
      res_data <= classes;
    end
  end

endmodule

[sv/adsc_checker.sv]
// ----------------------------------------------------------------------------
// adsc_checker: port-level checks for the classifier
// Flow and latency properties seen at the top-level ports.
// ----------------------------------------------------------------------------
module adsc_checker (
  input logic                clk,
  input logic                rst,
  input logic                ad_valid,
  input logic                ad_ready,
  input adsc_pkg::adsc_in_t  ad_data,
  input logic                res_valid,
  input logic                res_ready,
  input adsc_pkg::adsc_out_t res_data
);
  import adsc_pkg::*;

  // Held result stays put until taken.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

  // With the result slot free the input side never stalls.
  assert property (@(posedge clk) disable iff (rst)
    !res_valid || res_ready |-> ad_ready)
    else $error("input stalled with free result slot");

  // A last byte yields a result once the slot frees.
  assert property (@(posedge clk) disable iff (rst)
    (ad_valid && ad_ready && ad_data.last_byte) ##1 (!res_valid || res_ready)
    |=> res_valid)
    else $error("last byte gave no result");

  // Nothing is shown straight out of reset.
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind ble_ad_structure_classifier_unit adsc_checker u_adsc_checker (
  .clk       (clk),
  .rst       (rst),
  .ad_valid  (ad_valid),
  .ad_ready  (ad_ready),
  .ad_data   (ad_data),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res_data  (res_data)
);

[test/ble_ad_structure_classifier_unit_test.sv]
// ----------------------------------------------------------------------------
// ble_ad_structure_classifier_unit_test: self-checking bench for the classifier
// Feeds advertising-data payloads a byte per item, predicts both classes per
// payload in a scoreboard, and checks every result item under random stalls.
// ----------------------------------------------------------------------------
module ble_ad_structure_classifier_unit_test;
  import adsc_pkg::*;

  // AD type bytes the classifier recognizes
  localparam logic [7:0] END_OF_DATA     = 8'h00;  // zero length byte
  localparam logic [7:0] TYPE_FLAGS      = 8'h01;
  localparam logic [7:0] TYPE_UUID16_INC = 8'h02;
  localparam logic [7:0] TYPE_UUID16_ALL = 8'h03;
  localparam logic [7:0] TYPE_SHORT_NAME = 8'h08;
  localparam logic [7:0] TYPE_FULL_NAME  = 8'h09;
  localparam logic [7:0] TYPE_TX_POWER   = 8'h0A;
  localparam logic [7:0] TYPE_SVC_DATA   = 8'h16;
  localparam logic [7:0] TYPE_APPEARANCE = 8'h19;

  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;   // long result-side hold-off
  localparam int DRAIN_CYCLES = 8;     // idle time after the last result is checked

  typedef enum logic [1:0] {WANT_LEN, WANT_TYPE, IN_VALUE, HALTED} parse_phase_e;

  typedef enum logic [2:0] {
    KIND_OTHER, KIND_FLAGS, KIND_UUID16, KIND_SVC_DATA,
    KIND_NAME, KIND_APPEARANCE, KIND_TX_POWER
  } elem_kind_e;

  // --------------------------------------------------------------------------
  // Scoreboard: walks the payload exactly as the block should and queues one
  // expected classification per payload (on the item flagged last_byte).
  // --------------------------------------------------------------------------
  class ad_scoreboard;
    adsc_out_t    class_q[$];
    int           errors;
    parse_phase_e phase;
    logic [7:0]   left_cnt;    // bytes still owed by the open element
    logic [7:0]   taken_cnt;   // payload bytes parsed, stops at 255
    elem_kind_e   open_kind;
    logic [6:0]   kinds_done;  // one bit per kind of completed element

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase      = WANT_LEN;
      left_cnt   = '0;
      taken_cnt  = '0;
      open_kind  = KIND_OTHER;
      kinds_done = '0;
    endfunction

    function elem_kind_e kind_of(logic [7:0] t);
      case (t)
        TYPE_FLAGS:                       return KIND_FLAGS;
        TYPE_UUID16_INC, TYPE_UUID16_ALL: return KIND_UUID16;
        TYPE_SVC_DATA:                    return KIND_SVC_DATA;
        TYPE_SHORT_NAME, TYPE_FULL_NAME:  return KIND_NAME;
        TYPE_APPEARANCE:                  return KIND_APPEARANCE;
        TYPE_TX_POWER:                    return KIND_TX_POWER;
        default:                          return KIND_OTHER;
      endcase
    endfunction

    function void parse(logic [7:0] b);
      case (phase)
        WANT_LEN: begin
          if (b == END_OF_DATA) begin
            phase = HALTED;
          end else begin
            left_cnt = b;
            phase    = WANT_TYPE;
          end
        end
        WANT_TYPE: begin
          // length one: the type byte closes the element
          if (left_cnt <= 8'd1) begin
            kinds_done[kind_of(b)] = 1'b1;
            left_cnt = '0;
            phase    = WANT_LEN;
          end else begin
            left_cnt  = left_cnt - 8'd1;
            open_kind = kind_of(b);
            phase     = IN_VALUE;
          end
        end
        IN_VALUE: begin
          if (left_cnt != 0) left_cnt = left_cnt - 8'd1;
          if (left_cnt == 0) begin
            kinds_done[open_kind] = 1'b1;
            phase = WANT_LEN;
          end
        end
        default: ;
      endcase
    endfunction

    function void note_byte(adsc_in_t it);
      adsc_out_t  res;
      logic       non_flags;
      if (taken_cnt != 8'd255) begin
        taken_cnt = taken_cnt + 8'd1;
        parse(it.ad_byte);
      end
      if (it.last_byte) begin
        non_flags = kinds_done[KIND_OTHER] | kinds_done[KIND_NAME] |
                    kinds_done[KIND_APPEARANCE] | kinds_done[KIND_TX_POWER];
        if (kinds_done[KIND_SVC_DATA])                res.ad_class = AD_SVC_DATA;
        else if (kinds_done[KIND_UUID16])             res.ad_class = AD_UUID16;
        else if (kinds_done[KIND_FLAGS] && !non_flags) res.ad_class = AD_FLAGS_ONLY;
        else                                          res.ad_class = AD_OTHER;
        if (kinds_done[KIND_NAME])            res.mfg_class = MFG_NAME;
        else if (kinds_done[KIND_APPEARANCE]) res.mfg_class = MFG_APPEARANCE;
        else if (kinds_done[KIND_TX_POWER])   res.mfg_class = MFG_TX_POWER;
        else if (kinds_done[KIND_FLAGS])      res.mfg_class = MFG_FLAGS;
        else                                  res.mfg_class = MFG_ONLY;
        class_q.push_back(res);
        clear();
      end
    endfunction

    function void check_result(adsc_out_t got);
      adsc_out_t want;
      if (class_q.size() == 0) begin
        $error("result item with none expected: ad_class %0d mfg_class %0d",
               got.ad_class, got.mfg_class);
        errors++;
        return;
      end
      want = class_q.pop_front();
      if (got.ad_class !== want.ad_class) begin
        $error("ad_class expected %0d actual %0d", want.ad_class, got.ad_class);
        errors++;
      end
      if (got.mfg_class !== want.mfg_class) begin
        $error("mfg_class expected %0d actual %0d", want.mfg_class, got.mfg_class);
        errors++;
      end
    endfunction

    function int pending();
      return class_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block and its ports; every input is known from time zero.
  // --------------------------------------------------------------------------
  logic      clk;
  logic      rst       = 1'b1;
  logic      ad_valid  = 1'b0;
  logic      ad_ready;
  adsc_in_t  ad_data   = '0;
  logic      res_valid;
  logic      res_ready = 1'b0;
  adsc_out_t res_data;

  ble_ad_structure_classifier_unit dut (
    .clk       (clk),
    .rst       (rst),
    .ad_valid  (ad_valid),
    .ad_ready  (ad_ready),
    .ad_data   (ad_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  ad_scoreboard sb = new();

  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         hold_requests = 0;   // bumped by stimulus, served by the receiver
  int         items_sent    = 0;
  int         cycle_cnt     = 0;
  logic [7:0] payload_q[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("ble_ad_structure_classifier_unit_test failed");
    $finish;
  end

  // Result side: random ready, plus a long hold-off on request so that
  // finished payloads back up and the block has to stall its input.
  initial begin
    int hold_left;
    int hold_served;
    hold_left   = 0;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        res_ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES - 1;
        res_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Result monitor: values read at the edge are the ones the block saw.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && res_valid && res_ready) sb.check_result(res_data);
    end
  end

  // One byte item: optional idle gap, then hold valid until accepted.
  task automatic send_item(input adsc_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      ad_valid <= 1'b0;
      @(posedge clk);
    end
    ad_valid <= 1'b1;
    ad_data  <= it;
    @(posedge clk);
    while (!ad_ready) @(posedge clk);
    sb.note_byte(it);
    items_sent++;
  endtask

  task automatic send_payload();
    adsc_in_t it;
    for (int i = 0; i < payload_q.size(); i++) begin
      it.ad_byte   = payload_q[i];
      it.last_byte = (i == payload_q.size() - 1);
      send_item(it);
    end
  endtask

  function automatic logic [7:0] pick_type();
    case ($urandom_range(9))
      0:       return TYPE_FLAGS;
      1:       return TYPE_UUID16_INC;
      2:       return TYPE_UUID16_ALL;
      3:       return TYPE_SVC_DATA;
      4:       return TYPE_SHORT_NAME;
      5:       return TYPE_FULL_NAME;
      6:       return TYPE_APPEARANCE;
      7:       return TYPE_TX_POWER;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly well-formed elements with random content; some payloads end in a
  // zero length plus trailing bytes, a truncated element, or plain noise.
  task automatic build_random_payload();
    int shape;
    int elems;
    int len;
    int cut;
    payload_q.delete();
    shape = $urandom_range(99);
    elems = $urandom_range(4);
    if (shape < 10) begin
      repeat ($urandom_range(1, 12)) payload_q.push_back(8'($urandom_range(255)));
    end else begin
      for (int e = 0; e < elems; e++) begin
        len = $urandom_range(1, 6);
        payload_q.push_back(8'(len));
        payload_q.push_back(pick_type());
        for (int j = 1; j < len; j++) payload_q.push_back(8'($urandom_range(255)));
      end
      if (shape < 25) begin
        payload_q.push_back(END_OF_DATA);
        repeat ($urandom_range(3)) payload_q.push_back(8'($urandom_range(255)));
      end else if (shape < 45) begin
        // open element that the last byte cuts short
        len = $urandom_range(1, 255);
        cut = $urandom_range(0, (len < 6) ? len - 1 : 5);
        payload_q.push_back(8'(len));
        if (cut > 0) payload_q.push_back(pick_type());
        for (int j = 1; j < cut; j++) payload_q.push_back(8'($urandom_range(255)));
      end
    end
    if (payload_q.size() == 0) payload_q.push_back(END_OF_DATA);
  endtask

  // Past 255 bytes only the last flag matters.
  task automatic build_long_payload(input int total);
    int len;
    payload_q.delete();
    while (payload_q.size() < total) begin
      len = $urandom_range(1, 40);
      payload_q.push_back(8'(len));
      payload_q.push_back(pick_type());
      for (int j = 1; j < len; j++) payload_q.push_back(8'($urandom_range(255)));
    end
    while (payload_q.size() > total) void'(payload_q.pop_back());
  endtask

  // One name element filling the payload: closes on byte 255 (counted) or on
  // byte 256 (beyond the parse window, so not counted).
  task automatic build_boundary_payload(input logic [7:0] len);
    payload_q.delete();
    payload_q.push_back(len);
    payload_q.push_back(TYPE_FULL_NAME);
    while (payload_q.size() < int'(len) + 1) payload_q.push_back(8'($urandom_range(255)));
  endtask

  initial begin
    int base;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 28;
    recv_idle_pct = 45;

    // Directed payloads
    // empty content: zero length byte that is also the last
    payload_q = {END_OF_DATA};
    send_payload();
    // type-only service data, then type-only full uuid16 list
    payload_q = {8'h01, TYPE_SVC_DATA, 8'h01, TYPE_UUID16_ALL};
    send_payload();
    // partial uuid16 list, short name, flags
    payload_q = {8'h01, TYPE_UUID16_INC, 8'h01, TYPE_SHORT_NAME, 8'h01, TYPE_FLAGS};
    send_payload();
    // unknown type next to a full name
    payload_q = {8'h01, 8'hFF, 8'h01, TYPE_FULL_NAME};
    send_payload();
    // appearance, then a tx power element cut short by the last byte
    payload_q = {8'h01, TYPE_APPEARANCE, 8'h02, TYPE_TX_POWER};
    send_payload();
    // tx power, then a nonzero length byte as the last byte
    payload_q = {8'h01, TYPE_TX_POWER, 8'h05};
    send_payload();
    // flags, stop, and a trailing byte that must be ignored
    payload_q = {8'h02, TYPE_FLAGS, 8'h06, END_OF_DATA, 8'h01};
    send_payload();

    build_boundary_payload(8'hFE);
    send_payload();
    build_boundary_payload(8'hFF);
    send_payload();

    // Random part in three idle settings; the hold-off opens the last one.
    base = items_sent;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 28; recv_idle_pct = 45; end
        1: begin send_idle_pct = 45; recv_idle_pct = 28; end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_requests <= hold_requests + 1;
        end
      endcase
      while (items_sent - base < (ph + 1) * RANDOM_ITEMS / 3) begin
        if ($urandom_range(99) < 2) build_long_payload($urandom_range(256, 320));
        else build_random_payload();
        send_payload();
      end
    end
    ad_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ble_ad_structure_classifier_unit_test passed");
    end else begin
      $display("ble_ad_structure_classifier_unit_test failed");
    end
    $finish;
  end

endmodule

[files.f]
sv/adsc_pkg.sv
sv/adsc_parser.sv
sv/ble_ad_structure_classifier_unit.sv
sv/adsc_checker.sv
test/ble_ad_structure_classifier_unit_test.sv
